@@ hw/rtl/gcfb_pkg.sv @@
// ----------------------------------------------------------------------------
// gcfb_pkg
// Shared types, frame constants and the sentence code table for the
// configuration frame builder.
// ----------------------------------------------------------------------------
package gcfb_pkg;

	localparam int SENTENCE_COUNT = 18;
	localparam int TABLE_LEN      = 18;

	// Highest usable sentence index plus one, whichever bound is tighter.
	localparam logic [5:0] SENT_LIMIT =
		6'((SENTENCE_COUNT < TABLE_LEN) ? SENTENCE_COUNT : TABLE_LEN);

	// Request modes.
	localparam logic [1:0] MODE_RATE    = 2'd0;
	localparam logic [1:0] MODE_ENABLE  = 2'd1;
	localparam logic [1:0] MODE_DISABLE = 2'd2;

	// Frame bytes.
	localparam logic [7:0] SYNC_1    = 8'hB5;
	localparam logic [7:0] SYNC_2    = 8'h62;
	localparam logic [7:0] CLASS_CFG = 8'h06;
	localparam logic [7:0] ID_RATE   = 8'h08;
	localparam logic [7:0] ID_MSG    = 8'h01;
	localparam logic [7:0] LEN_RATE  = 8'h06;
	localparam logic [7:0] LEN_MSG   = 8'h03;
	localparam logic [7:0] NMEA_CLS  = 8'hF0;
	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONE  = 8'h01;

	// Index of the final byte in each frame type.
	localparam logic [3:0] LAST_RATE = 4'd13;
	localparam logic [3:0] LAST_MSG  = 4'd10;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	// Commands from the sequencer to the checksum accumulator.
	typedef struct packed {
		logic       clear;
		logic       add;
		logic [7:0] data;
	} cksum_ctl_t;

	function automatic logic [7:0] sentence_id(input logic [4:0] idx);
		logic [7:0] id;
		case (idx)
			5'd0:    id = 8'h00;
			5'd1:    id = 8'h01;
			5'd2:    id = 8'h02;
			5'd3:    id = 8'h03;
			5'd4:    id = 8'h04;
			5'd5:    id = 8'h05;
			5'd6:    id = 8'h06;
			5'd7:    id = 8'h07;
			5'd8:    id = 8'h08;
			5'd9:    id = 8'h09;
			5'd10:   id = 8'h0A;
			5'd11:   id = 8'h0D;
			5'd12:   id = 8'h0F;
			5'd13:   id = 8'h40;
			5'd14:   id = 8'h41;
			5'd15:   id = 8'h42;
			5'd16:   id = 8'h43;
			5'd17:   id = 8'h44;
			default: id = 8'h00;
		endcase
		return id;
	endfunction

endpackage

@@ hw/rtl/gcfb_cksum.sv @@
// ----------------------------------------------------------------------------
// gcfb_cksum
// Fletcher-8 accumulator for the frame bytes from class through payload: one add per cycle while add is set.
// ----------------------------------------------------------------------------
module gcfb_cksum (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gcfb_pkg::cksum_ctl_t  ctl,
	output logic [7:0]            ck_a,
	output logic [7:0]            ck_b
);
	import gcfb_pkg::*;

	logic [7:0] ck_a_q;
	logic [7:0] ck_b_q;
	logic [7:0] sum_a;

	assign sum_a = ck_a_q + ctl.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ck_a_q <= 8'h00;
			ck_b_q <= 8'h00;
		end else if (ctl.clear) begin
			ck_a_q <= 8'h00;
			ck_b_q <= 8'h00;
		end else if (ctl.add) begin
			ck_a_q <= sum_a;
			ck_b_q <= ck_b_q + sum_a;
		end
	end

	assign ck_a = ck_a_q;
	assign ck_b = ck_b_q;

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> (ck_a_q == 8'h00) && (ck_b_q == 8'h00))
		else $error("checksum not cleared at frame start");

endmodule

@@ hw/rtl/gcfb_ctrl.sv @@
// ----------------------------------------------------------------------------
// gcfb_ctrl
// Request register, byte counter and frame byte selection.
// ----------------------------------------------------------------------------
module gcfb_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic [15:0]           rate_ms,
	input  logic [4:0]            sentence,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            tx_byte,
	output logic                  last_byte,
	output gcfb_pkg::cksum_ctl_t  ck_ctl,
	input  logic [7:0]            ck_a,
	input  logic [7:0]            ck_b
);
	import gcfb_pkg::*;

	state_t      state_q;
	state_t      state_d;
	logic [3:0]  idx_q;
	logic        is_rate_q;
	logic        enable_q;
	logic [15:0] rate_q;
	logic [4:0]  sel_q;

	logic        in_fire;
	logic        out_fire;
	logic        req_ok;
	logic [3:0]  last_idx;
	logic [7:0]  byte_d;
	logic        in_sum;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// Mode 3 and, in modes 1 and 2, out-of-range sentences are taken and dropped.
	always_comb begin
		unique case (mode)
			MODE_RATE:                 req_ok = 1'b1;
			MODE_ENABLE, MODE_DISABLE: req_ok = ({1'b0, sentence} < SENT_LIMIT);
			default:                   req_ok = 1'b0;
		endcase
	end

	assign last_idx = is_rate_q ? LAST_RATE : LAST_MSG;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire && req_ok) state_d = ST_EMIT;
			ST_EMIT: if (out_fire && idx_q == last_idx) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready  = 1'b1;
			ST_EMIT: out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= 4'd0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				idx_q <= 4'd0;
			end else if (out_fire) begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			is_rate_q <= (mode == MODE_RATE);
			enable_q  <= (mode == MODE_ENABLE);
			rate_q    <= rate_ms;
			sel_q     <= sentence;
		end
	end

	always_comb begin
		case (idx_q)
			4'd0:    byte_d = SYNC_1;
			4'd1:    byte_d = SYNC_2;
			4'd2:    byte_d = CLASS_CFG;
			4'd3:    byte_d = is_rate_q ? ID_RATE : ID_MSG;
			4'd4:    byte_d = is_rate_q ? LEN_RATE : LEN_MSG;
			4'd5:    byte_d = BYTE_ZERO;
			4'd6:    byte_d = is_rate_q ? rate_q[7:0] : NMEA_CLS;
			4'd7:    byte_d = is_rate_q ? rate_q[15:8] : sentence_id(sel_q);
			4'd8:    byte_d = (is_rate_q || enable_q) ? BYTE_ONE : BYTE_ZERO;
			4'd9:    byte_d = is_rate_q ? BYTE_ZERO : ck_a;
			4'd10:   byte_d = is_rate_q ? BYTE_ZERO : ck_b;
			4'd12:   byte_d = ck_a;
			4'd13:   byte_d = ck_b;
			default: byte_d = BYTE_ZERO;
		endcase
	end

	// The checksum covers class through the final payload byte.
	assign in_sum = (idx_q >= 4'd2) && (idx_q < (last_idx - 4'd1));

	assign tx_byte   = byte_d;
	assign last_byte = (idx_q == last_idx);

	assign ck_ctl.clear = in_fire;
	assign ck_ctl.add   = out_fire && in_sum;
	assign ck_ctl.data  = byte_d;

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output sides active together");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (idx_q <= last_idx))
		else $error("byte counter ran past the end of the frame");

	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && last_byte) |=> in_ready)
		else $error("block not idle after the final byte");

	a_first_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && req_ok) |=> (out_valid && tx_byte == SYNC_1))
		else $error("frame did not start with the first sync byte");

endmodule

@@ hw/rtl/gnss_config_frame_builder_core.sv @@
// ----------------------------------------------------------------------------
// gnss_config_frame_builder_core
// Builds one binary receiver configuration frame per usable request, byte by byte.
// ----------------------------------------------------------------------------
// Usage:
// A request (mode, rate_ms, sentence) is taken on the input channel when
// in_valid and in_ready are both high. in_ready is high only while no frame
// is being sent. Mode 0 gives a 14-byte rate frame; modes 1 and 2 give an
// 11-byte sentence enable or disable frame. Mode 3, or in modes 1 and 2 a
// sentence index at or above the table size, is taken and produces nothing.
// The frame leaves on the output channel one item per byte (tx_byte), with
// last_byte set on the closing checksum byte. The first byte is offered in
// the cycle after the request is taken, and with out_ready held high one
// byte leaves each cycle. The byte counter steps as each byte is accepted,
// and a single Fletcher adder is updated as each byte from the class byte
// through the final payload byte is accepted. When the receiver stalls,
// the current byte simply holds. Reset returns the block to idle with no
// frame pending.
// ----------------------------------------------------------------------------
module gnss_config_frame_builder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [15:0] rate_ms,
	input  logic [4:0]  sentence,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  tx_byte,
	output logic        last_byte
);
	import gcfb_pkg::*;

	cksum_ctl_t ck_ctl;
	logic [7:0] ck_a;
	logic [7:0] ck_b;

	gcfb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.rate_ms   (rate_ms),
		.sentence  (sentence),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tx_byte   (tx_byte),
		.last_byte (last_byte),
		.ck_ctl    (ck_ctl),
		.ck_a      (ck_a),
		.ck_b      (ck_b)
	);

	gcfb_cksum u_cksum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ck_ctl),
		.ck_a   (ck_a),
		.ck_b   (ck_b)
	);

endmodule

@@ dv/gcfb_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcfb_frame_checker
// Watches both channels of the configuration frame builder. Every accepted
// request is expanded into the bytes of its frame, checksum included, and
// each byte that leaves the block is compared with the oldest one waiting.
// ----------------------------------------------------------------------------
module gcfb_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [15:0] rate_ms,
	input  logic [4:0]  sentence,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  tx_byte,
	input  logic        last_byte,
	output int          fail_count,
	output int          pending
);
	import gcfb_pkg::*;

	localparam int MAX_FRAME_LEN = 14;
	localparam int PRINT_LIMIT   = 40;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	// Message ids of the sentence table; the class byte is common to all.
	localparam logic [7:0] MSG_IDS [TABLE_LEN] = '{
		8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
		8'h09, 8'h0A, 8'h0D, 8'h0F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44
	};

	frame_byte_t frame_bytes_due[$];
	int          bytes_seen;

	initial begin
		fail_count = 0;
		pending    = 0;
		bytes_seen = 0;
	end

	task automatic report_mismatch(input string what, input int want, input int got);
		if (fail_count < PRINT_LIMIT) begin
			$display("%0t ns: byte %0d: %s: expected %0h, got %0h",
				$realtime, bytes_seen, what, want, got);
		end
		fail_count++;
	endtask

	// Builds the frame that a request causes and queues its bytes.
	task automatic queue_frame(input logic [1:0] req_mode, input logic [15:0] req_rate,
			input logic [4:0] req_sentence);
		logic [7:0] frame [MAX_FRAME_LEN];
		logic [7:0] ck_a;
		logic [7:0] ck_b;
		int         len;
		int         i;
		len  = 0;
		ck_a = 8'h00;
		ck_b = 8'h00;
		frame = '{default: BYTE_ZERO};
		if (req_mode == MODE_RATE) begin
			frame = '{SYNC_1, SYNC_2, CLASS_CFG, ID_RATE, LEN_RATE, BYTE_ZERO,
				req_rate[7:0], req_rate[15:8], BYTE_ONE, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO,
				BYTE_ZERO, BYTE_ZERO};
			len = 14;
		end else if ((req_mode == MODE_ENABLE || req_mode == MODE_DISABLE) &&
				{1'b0, req_sentence} < SENT_LIMIT) begin
			frame[0] = SYNC_1;
			frame[1] = SYNC_2;
			frame[2] = CLASS_CFG;
			frame[3] = ID_MSG;
			frame[4] = LEN_MSG;
			frame[5] = BYTE_ZERO;
			frame[6] = NMEA_CLS;
			frame[7] = MSG_IDS[req_sentence];
			frame[8] = (req_mode == MODE_ENABLE) ? BYTE_ONE : BYTE_ZERO;
			len = 11;
		end
		if (len == 0) begin
			return;
		end
		// Fletcher sums run from the class byte to the end of the payload.
		for (i = 2; i < len - 2; i++) begin
			ck_a = ck_a + frame[i];
			ck_b = ck_b + ck_a;
		end
		frame[len - 2] = ck_a;
		frame[len - 1] = ck_b;
		for (i = 0; i < len; i++) begin
			frame_bytes_due.push_back('{data: frame[i], last: (i == len - 1)});
		end
		pending += len;
	endtask

	always @(posedge clk) begin
		frame_byte_t due;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				queue_frame(mode, rate_ms, sentence);
			end
			if (out_valid && out_ready) begin
				if (frame_bytes_due.size() == 0) begin
					report_mismatch("byte with no frame pending", 0, tx_byte);
				end else begin
					due = frame_bytes_due.pop_front();
					pending--;
					if (tx_byte !== due.data) begin
						report_mismatch("tx_byte", due.data, tx_byte);
					end
					if (last_byte !== due.last) begin
						report_mismatch("last_byte", due.last, last_byte);
					end
				end
				bytes_seen++;
			end
		end
	end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests into the configuration frame builder and stalls its byte
// output, while the frame checker predicts and compares every byte.
// A directed part covers the field extremes, every mode, the ignored
// requests and a full disable-all sweep; random bursts of requests follow.
// ----------------------------------------------------------------------------
module testbench;
	import gcfb_pkg::*;

	localparam logic [1:0] MODE_UNUSED  = 2'd3;
	localparam int CYCLE_LIMIT          = 400000;
	localparam int RANDOM_FRAMES        = 355;
	localparam int LONG_HOLD_CYCLES     = 250;
	localparam int STALL_NONE           = 0;
	localparam int STALL_RANDOM         = 1;
	localparam int STALL_PERIODIC       = 2;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [15:0] rate_ms;
	logic [4:0]  sentence;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  tx_byte;
	logic        last_byte;

	int fail_count;
	int pending;
	bit long_hold_req;
	bit draining;
	int random_frames;

	gnss_config_frame_builder_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.rate_ms   (rate_ms),
		.sentence  (sentence),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tx_byte   (tx_byte),
		.last_byte (last_byte)
	);

	gcfb_frame_checker frame_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.rate_ms    (rate_ms),
		.sentence   (sentence),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.tx_byte    (tx_byte),
		.last_byte  (last_byte),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offers one request and returns at the edge where it is taken.
	task automatic send_request(input logic [1:0] req_mode, input logic [15:0] req_rate,
			input logic [4:0] req_sentence);
		@(negedge clk);
		in_valid = 1'b1;
		mode     = req_mode;
		rate_ms  = req_rate;
		sentence = req_sentence;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	// Idles the request channel for the given number of cycles, with junk payload.
	task automatic pause_sender(input int cycles);
		@(negedge clk);
		in_valid = 1'b0;
		mode     = 2'($urandom_range(3, 0));
		rate_ms  = 16'($urandom_range(16'hFFFF, 0));
		sentence = 5'($urandom_range(31, 0));
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic wait_frames_done();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
	endtask

	// A random request; counts those that should produce a frame.
	task automatic send_random_request();
		int         pick;
		logic [15:0] rate;
		logic [1:0]  msg_mode;
		pick     = $urandom_range(99, 0);
		rate     = 16'($urandom_range(16'hFFFF, 0));
		msg_mode = ($urandom_range(1, 0) == 0) ? MODE_ENABLE : MODE_DISABLE;
		if (pick < 5) begin
			rate = ($urandom_range(1, 0) == 0) ? 16'h0000 : 16'hFFFF;
		end
		if (pick < 40) begin
			send_request(MODE_RATE, rate, 5'($urandom_range(31, 0)));
			random_frames++;
		end else if (pick < 88) begin
			send_request(msg_mode, rate, 5'($urandom_range(int'(SENT_LIMIT) - 1, 0)));
			random_frames++;
		end else if (pick < 94) begin
			send_request(msg_mode, rate, 5'($urandom_range(31, int'(SENT_LIMIT))));
		end else begin
			send_request(MODE_UNUSED, rate, 5'($urandom_range(31, 0)));
		end
	endtask

	initial begin
		int  burst;
		int  gap;
		int  idx;
		bit  hold_done;
		bit  drain_done;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		mode          = MODE_RATE;
		rate_ms       = 16'h0000;
		sentence      = 5'd0;
		long_hold_req = 1'b0;
		draining      = 1'b0;
		random_frames = 0;
		hold_done     = 1'b0;
		drain_done    = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		send_request(MODE_RATE, 16'h0000, 5'd31);
		send_request(MODE_RATE, 16'hFFFF, 5'd0);
		send_request(MODE_RATE, 16'h1234, 5'd17);
		send_request(MODE_ENABLE, 16'hFFFF, 5'd0);
		send_request(MODE_ENABLE, 16'h0000, 5'd17);
		// Requests that the block takes but answers with nothing.
		send_request(MODE_ENABLE, 16'h0000, 5'd18);
		send_request(MODE_DISABLE, 16'hFFFF, 5'd31);
		send_request(MODE_UNUSED, 16'h5555, 5'd3);
		// Disabling every table entry in turn amounts to a disable-all command.
		for (idx = 0; idx < int'(SENT_LIMIT); idx++) begin
			send_request(MODE_DISABLE, 16'($urandom_range(16'hFFFF, 0)), 5'(idx));
		end
		wait_frames_done();

		while (random_frames < RANDOM_FRAMES) begin
			burst = $urandom_range(12, 1);
			repeat (burst) send_random_request();
			if (!hold_done && random_frames >= 150) begin
				long_hold_req = 1'b1;
				hold_done     = 1'b1;
			end
			if (!drain_done && random_frames >= 300) begin
				wait_frames_done();
				drain_done = 1'b1;
			end
			gap = $urandom_range(3, 0);
			if (gap != 0) begin
				gap = ($urandom_range(15, 0) == 0) ? 40 : $urandom_range(8, 1);
				pause_sender(gap);
			end
		end

		draining = 1'b1;
		wait_frames_done();
		repeat (30) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Receiver: stretches of free flow, random stalls and periodic stalls, plus
	// one long hold-off on request so that the block backs up into its input.
	initial begin
		int pattern;
		int span;
		int period;
		int phase;
		out_ready = 1'b0;
		forever begin
			if (draining) begin
				@(negedge clk);
				out_ready = 1'b1;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				@(negedge clk);
				out_ready = 1'b0;
				repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				pattern = $urandom_range(STALL_PERIODIC, STALL_NONE);
				span    = $urandom_range(60, 5);
				period  = $urandom_range(6, 2);
				phase   = 0;
				repeat (span) begin
					@(negedge clk);
					case (pattern)
						STALL_NONE:     out_ready = 1'b1;
						STALL_RANDOM:   out_ready = ($urandom_range(2, 0) != 0);
						default:        out_ready = (phase % period == 0);
					endcase
					phase++;
				end
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

endmodule
